>>> rtl/hmlv_pkg.sv
// ----------------------------------------------------------------------------
// hmlv_pkg
// Shared types, constants and character classes for the height map line
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package hmlv_pkg;

	localparam int unsigned MAX_TOKENS_DEF = 4096;
	localparam int unsigned MAX_LINES_DEF  = 4096;

	localparam int unsigned CNT_OUT_W = 13;
	localparam int unsigned HEX_CNT_W = 3;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [HEX_CNT_W-1:0] HEX_MAX = 3'd6;
	localparam logic [HEX_CNT_W-1:0] HEX_TWO = 3'd2;
	localparam logic [HEX_CNT_W-1:0] HEX_FOUR = 3'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SYNTAX   = 2'd1,
		ST_COLUMNS  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		PH_START  = 7'b0000001,
		PH_GAP    = 7'b0000010,
		PH_SIGN   = 7'b0000100,
		PH_DIGITS = 7'b0001000,
		PH_COMMA  = 7'b0010000,
		PH_ZERO   = 7'b0100000,
		PH_HEX    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] lines;
		logic [CNT_OUT_W-1:0] tokens;
		status_t              status;
	} res_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
			((c >= CH_UA) && (c <= CH_UF));
	endfunction

endpackage

`default_nettype wire

>>> rtl/hmlv_scan.sv
// ----------------------------------------------------------------------------
// hmlv_scan
// Token scanner state, token and line counters, first line width and the
// sticky error code, advanced by one character or line end per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hmlv_scan
	import hmlv_pkg::*;
#(
	parameter int unsigned MAX_TOKENS = MAX_TOKENS_DEF,
	parameter int unsigned MAX_LINES  = MAX_LINES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_code,
	input  wire logic       line_end,
	output res_t            cur,
	output res_t            nxt
);

	localparam int unsigned TW = $clog2(MAX_TOKENS + 1);
	localparam int unsigned LW = $clog2(MAX_LINES + 1);

	phase_t                phase_q, phase_d;
	logic [HEX_CNT_W-1:0]  hex_q, hex_d;
	logic [TW-1:0]         tok_q, tok_d;
	logic [TW-1:0]         first_q, first_d;
	logic [LW-1:0]         line_q, line_d;
	status_t               err_q, err_d;

	logic tok_full;
	logic line_full;
	logic hex_len_ok;
	logic end_ok;

	assign tok_full   = tok_q >= TW'(MAX_TOKENS);
	assign line_full  = line_q >= LW'(MAX_LINES);
	assign hex_len_ok = (hex_q == HEX_TWO) || (hex_q == HEX_FOUR) || (hex_q == HEX_MAX);

	always_comb begin
		unique case (phase_q)
			PH_START:  end_ok = 1'b1;
			PH_GAP:    end_ok = tok_q != '0;
			PH_DIGITS: end_ok = 1'b1;
			PH_HEX:    end_ok = hex_len_ok;
			default:   end_ok = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		tok_d   = tok_q;
		first_d = first_q;
		line_d  = line_q;
		err_d   = err_q;
		if (err_q == ST_OK) begin
			if (line_end) begin
				if (!end_ok) begin
					err_d = ST_SYNTAX;
				end else if ((line_q != '0) && (tok_q != first_q)) begin
					err_d = ST_COLUMNS;
				end else if (line_full) begin
					err_d = ST_OVERFLOW;
				end else begin
					if (line_q == '0) begin
						first_d = tok_q;
					end
					line_d  = line_q + LW'(1);
					tok_d   = '0;
					hex_d   = '0;
					phase_d = PH_START;
				end
			end else begin
				unique case (phase_q)
					PH_START, PH_GAP: begin
						if (char_code == CH_SPACE) begin
							phase_d = PH_GAP;
						end else if ((char_code == CH_MINUS) || is_dec(char_code)) begin
							if (tok_full) begin
								err_d = ST_OVERFLOW;
							end else begin
								tok_d   = tok_q + TW'(1);
								phase_d = (char_code == CH_MINUS) ? PH_SIGN : PH_DIGITS;
							end
						end else begin
							err_d = ST_SYNTAX;
						end
					end
					PH_SIGN: begin
						if (is_dec(char_code)) begin
							phase_d = PH_DIGITS;
						end else begin
							err_d = ST_SYNTAX;
						end
					end
					PH_DIGITS: begin
						if (is_dec(char_code)) begin
							phase_d = PH_DIGITS;
						end else if (char_code == CH_COMMA) begin
							phase_d = PH_COMMA;
						end else if (char_code == CH_SPACE) begin
							phase_d = PH_GAP;
						end else begin
							err_d = ST_SYNTAX;
						end
					end
					PH_COMMA: begin
						if (char_code == CH_ZERO) begin
							phase_d = PH_ZERO;
						end else begin
							err_d = ST_SYNTAX;
						end
					end
					PH_ZERO: begin
						if (char_code == CH_X) begin
							hex_d   = '0;
							phase_d = PH_HEX;
						end else begin
							err_d = ST_SYNTAX;
						end
					end
					PH_HEX: begin
						if (is_hex(char_code)) begin
							if (hex_q >= HEX_MAX) begin
								err_d = ST_SYNTAX;
							end else begin
								hex_d = hex_q + HEX_CNT_W'(1);
							end
						end else if ((char_code == CH_SPACE) && hex_len_ok) begin
							phase_d = PH_GAP;
						end else begin
							err_d = ST_SYNTAX;
						end
					end
					default: err_d = ST_SYNTAX;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			hex_q   <= '0;
			tok_q   <= '0;
			first_q <= '0;
			line_q  <= '0;
			err_q   <= ST_OK;
		end else if (step) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			tok_q   <= tok_d;
			first_q <= first_d;
			line_q  <= line_d;
			err_q   <= err_d;
		end
	end

	assign cur.status = err_q;
	assign cur.tokens = CNT_OUT_W'(tok_q);
	assign cur.lines  = CNT_OUT_W'(line_q);
	assign nxt.status = err_d;
	assign nxt.tokens = CNT_OUT_W'(tok_d);
	assign nxt.lines  = CNT_OUT_W'(line_d);

endmodule

`default_nettype wire

>>> rtl/height_map_line_validator.sv
// ----------------------------------------------------------------------------
// height_map_line_validator
// Streaming syntax and column check of a text height map.
// ----------------------------------------------------------------------------
// One character beat per cycle in while m_tready is high (tlast marks a
// line end, its tdata is ignored), one status beat out per input beat.
// An input register feeds the scanner state update and result register.
// Sustained rate is one beat per clock unless the output stalls; the
// scanner state update is the only loop. Errors are sticky until reset.
`default_nettype none

module height_map_line_validator
	import hmlv_pkg::*;
#(
	parameter int unsigned MAX_TOKENS = MAX_TOKENS_DEF,
	parameter int unsigned MAX_LINES  = MAX_LINES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [7:0] char_code
	input  wire logic                  s_tlast,  // line_end
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata   // [1:0] status, [14:2] tokens_in_line,
	                                             // [27:15] lines_accepted, [31:28] zero
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       load_s2;
	res_t       cur;
	res_t       nxt;

	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	hmlv_scan #(
		.MAX_TOKENS (MAX_TOKENS),
		.MAX_LINES  (MAX_LINES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (load_s2),
		.char_code (char_s1),
		.line_end  (end_s1),
		.cur       (cur),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), res_s2};

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(cur.status != ST_OK) |=> (cur.status == $past(cur.status)))
		else $error("error code changed after being set");

	a_line_clears_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && (nxt.lines != cur.lines)) |=> (cur.tokens == '0))
		else $error("token count not cleared on accepted line");

	a_char_keeps_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && !end_s1) |=> (cur.lines == $past(cur.lines)))
		else $error("line count moved on a character beat");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> (valid_s1 && $stable(char_s1) && $stable(end_s1)))
		else $error("input stage dropped a beat");

endmodule

`default_nettype wire

>>> test/tb_height_map_line_validator.sv
// ----------------------------------------------------------------------------
// tb_height_map_line_validator
// Self-checking stream testbench for the height map line validator.
// ----------------------------------------------------------------------------
// Characters are driven beat by beat on the slave side; a behavioral scanner
// in the bench predicts the status beat for every accepted beat and a
// checker compares each master beat field by field. Errors are sticky until
// reset, so the run is one long file of well-formed three-column lines
// (directed, random, then under a long output stall) that ends in one
// randomly chosen fault, followed by beats the block must ignore.

module tb_height_map_line_validator;
	import hmlv_pkg::*;

	localparam int LINE_WIDTH = 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [7:0] CH_UX = 8'h58;

	typedef enum int {
		FAULT_SPACES,
		FAULT_MINUS,
		FAULT_CUT_COLOUR,
		FAULT_UPPER_X,
		FAULT_LONG_HEX,
		FAULT_BAD_CHAR,
		FAULT_COLUMNS
	} fault_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] char_code
	logic                  s_tlast = 1'b0; // line_end
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [1:0] status, [14:2] tokens_in_line,
	                                       // [27:15] lines_accepted, [31:28] zero

	// scanner state mirrored by the bench
	phase_t               sc_phase = PH_START;
	logic [HEX_CNT_W-1:0] sc_hex = '0;
	int                   sc_tokens = 0;
	int                   sc_width = 0;
	int                   sc_lines = 0;
	status_t              sc_err = ST_OK;

	res_t expected_status_q[$];
	int   mismatch_cnt = 0;
	int   items_sent = 0;
	int   cycle_cnt = 0;
	int   hold_request = 0;
	bit   idle_on = 1'b0;

	height_map_line_validator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_digit_ch(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_hex_ch(input logic [7:0] c);
		return is_digit_ch(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic bit colour_len_ok();
		return sc_hex == HEX_TWO || sc_hex == HEX_FOUR || sc_hex == HEX_MAX;
	endfunction

	function automatic void open_token(input phase_t next_phase);
		if (sc_tokens >= MAX_TOKENS_DEF) begin
			sc_err = ST_OVERFLOW;
		end else begin
			sc_tokens++;
			sc_phase = next_phase;
		end
	endfunction

	function automatic void close_line();
		bit ok;
		case (sc_phase)
			PH_START, PH_DIGITS: ok = 1'b1;
			PH_GAP:              ok = sc_tokens != 0;
			PH_HEX:              ok = colour_len_ok();
			default:             ok = 1'b0;
		endcase
		if (!ok) begin
			sc_err = ST_SYNTAX;
		end else if (sc_lines != 0 && sc_tokens != sc_width) begin
			sc_err = ST_COLUMNS;
		end else if (sc_lines >= MAX_LINES_DEF) begin
			sc_err = ST_OVERFLOW;
		end else begin
			if (sc_lines == 0)
				sc_width = sc_tokens;
			sc_lines++;
			sc_tokens = 0;
			sc_hex = '0;
			sc_phase = PH_START;
		end
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		case (sc_phase)
			PH_START, PH_GAP: begin
				if (c == CH_SPACE)
					sc_phase = PH_GAP;
				else if (c == CH_MINUS)
					open_token(PH_SIGN);
				else if (is_digit_ch(c))
					open_token(PH_DIGITS);
				else
					sc_err = ST_SYNTAX;
			end
			PH_SIGN: begin
				if (is_digit_ch(c))
					sc_phase = PH_DIGITS;
				else
					sc_err = ST_SYNTAX;
			end
			PH_DIGITS: begin
				if (is_digit_ch(c))
					sc_phase = PH_DIGITS;
				else if (c == CH_COMMA)
					sc_phase = PH_COMMA;
				else if (c == CH_SPACE)
					sc_phase = PH_GAP;
				else
					sc_err = ST_SYNTAX;
			end
			PH_COMMA: begin
				if (c == CH_ZERO)
					sc_phase = PH_ZERO;
				else
					sc_err = ST_SYNTAX;
			end
			PH_ZERO: begin
				if (c == CH_X) begin
					sc_hex = '0;
					sc_phase = PH_HEX;
				end else begin
					sc_err = ST_SYNTAX;
				end
			end
			PH_HEX: begin
				if (is_hex_ch(c)) begin
					if (sc_hex >= HEX_MAX)
						sc_err = ST_SYNTAX;
					else
						sc_hex++;
				end else if (c == CH_SPACE && colour_len_ok()) begin
					sc_phase = PH_GAP;
				end else begin
					sc_err = ST_SYNTAX;
				end
			end
			default: sc_err = ST_SYNTAX;
		endcase
	endfunction

	function automatic void predict_status(input logic [7:0] c, input logic eol);
		res_t r;
		if (sc_err == ST_OK) begin
			if (eol)
				close_line();
			else
				scan_char(c);
		end
		r.status = sc_err;
		r.tokens = CNT_OUT_W'(sc_tokens);
		r.lines  = CNT_OUT_W'(sc_lines);
		expected_status_q.push_back(r);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_hex();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10)
			return CH_ZERO + 8'(k);
		else if (k < 16)
			return CH_LA + 8'(k - 10);
		return CH_UA + 8'(k - 16);
	endfunction

	// any character that can neither start a token nor follow a digit or a space
	function automatic logic [7:0] rand_junk();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_digit_ch(c) || c == CH_SPACE || c == CH_MINUS || c == CH_COMMA);
		return c;
	endfunction

	task automatic send_beat(input logic [7:0] c, input logic eol);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eol;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_status(c, eol);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	// char_code is don't-care on a line end beat, so it carries noise
	task automatic end_line();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_token();
		int n;
		if ($urandom_range(0, 3) == 0)
			send_beat(CH_MINUS, 1'b0);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
		repeat (n) send_beat(rand_digit(), 1'b0);
		if ($urandom_range(0, 2) == 0) begin
			send_beat(CH_COMMA, 1'b0);
			send_beat(CH_ZERO, 1'b0);
			send_beat(CH_X, 1'b0);
			n = 2 * $urandom_range(1, 3);
			repeat (n) send_beat(rand_hex(), 1'b0);
		end
	endtask

	task automatic send_line(input int ntok);
		if (ntok > 0) begin
			repeat ($urandom_range(0, 2)) send_beat(CH_SPACE, 1'b0);
			for (int i = 0; i < ntok; i++) begin
				if (i > 0)
					repeat ($urandom_range(1, 3)) send_beat(CH_SPACE, 1'b0);
				send_token();
			end
			repeat ($urandom_range(0, 2)) send_beat(CH_SPACE, 1'b0);
		end
		end_line();
	endtask

	task automatic send_lead_tokens();
		repeat ($urandom_range(0, LINE_WIDTH - 1)) begin
			send_token();
			send_beat(CH_SPACE, 1'b0);
		end
	endtask

	task automatic test_directed_lines();
		idle_on = 1'b1;
		send_text("-0,0xaF 9 1");
		end_line();
		send_text(" 5,0xA0f9e8  -3 7 ");
		end_line();
	endtask

	task automatic test_random_lines();
		int stop_at;
		stop_at = items_sent + 600;
		while (items_sent < stop_at) begin
			idle_on = $urandom_range(0, 3) != 0;
			send_line(LINE_WIDTH);
		end
	endtask

	task automatic test_output_stall();
		idle_on = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (8) send_line(LINE_WIDTH);
	endtask

	task automatic test_sticky_fault();
		fault_e f;
		int     n;
		idle_on = 1'b0;
		f = fault_e'($urandom_range(0, int'(FAULT_COLUMNS)));
		case (f)
			FAULT_SPACES: begin
				repeat ($urandom_range(1, 4)) send_beat(CH_SPACE, 1'b0);
				end_line();
			end
			FAULT_MINUS: begin
				send_lead_tokens();
				send_beat(CH_MINUS, 1'b0);
				case ($urandom_range(0, 2))
					0:       end_line();
					1:       send_beat(CH_SPACE, 1'b0);
					default: send_beat(rand_junk(), 1'b0);
				endcase
			end
			FAULT_CUT_COLOUR: begin
				send_lead_tokens();
				send_beat(rand_digit(), 1'b0);
				send_beat(CH_COMMA, 1'b0);
				n = $urandom_range(0, 2);
				if (n >= 1)
					send_beat(CH_ZERO, 1'b0);
				if (n == 2) begin
					send_beat(CH_X, 1'b0);
					n = $urandom_range(0, 3);
					n = (n == 0) ? 0 : 2 * n - 1;
					repeat (n) send_beat(rand_hex(), 1'b0);
				end
				if ($urandom_range(0, 1) == 0)
					end_line();
				else
					send_beat(CH_SPACE, 1'b0);
			end
			FAULT_UPPER_X: begin
				send_lead_tokens();
				send_beat(rand_digit(), 1'b0);
				send_beat(CH_COMMA, 1'b0);
				send_beat(CH_ZERO, 1'b0);
				send_beat(CH_UX, 1'b0);
				send_beat(rand_hex(), 1'b0);
				send_beat(rand_hex(), 1'b0);
			end
			FAULT_LONG_HEX: begin
				send_lead_tokens();
				send_beat(rand_digit(), 1'b0);
				send_beat(CH_COMMA, 1'b0);
				send_beat(CH_ZERO, 1'b0);
				send_beat(CH_X, 1'b0);
				repeat (7) send_beat(rand_hex(), 1'b0);
			end
			FAULT_BAD_CHAR: begin
				send_lead_tokens();
				if ($urandom_range(0, 1) == 0)
					send_beat(rand_digit(), 1'b0);
				send_beat(rand_junk(), 1'b0);
			end
			default: begin
				// column mismatch
				case ($urandom_range(0, 2))
					0:       send_line(0);
					1:       send_line(LINE_WIDTH - 1);
					default: send_line(LINE_WIDTH + $urandom_range(1, 3));
				endcase
			end
		endcase
		// everything after the fault must leave the status beats frozen
		repeat (30) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic report_mismatch(input string what, input res_t want, input res_t got);
		if (mismatch_cnt < 10)
			$display("%s: status %0d/%0d tokens %0d/%0d lines %0d/%0d (expected/actual)",
				what, want.status, got.status, want.tokens, got.tokens,
				want.lines, got.lines);
		mismatch_cnt++;
	endtask

	initial begin : result_drain
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 6);
			end
			m_tready <= stall_left == 0;
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(res_t)-1:0];
			if (expected_status_q.size() == 0) begin
				want = '0;
				report_mismatch("unexpected status beat", want, got);
			end else begin
				want = expected_status_q.pop_front();
				if (got.status !== want.status || got.tokens !== want.tokens ||
						got.lines !== want.lines)
					report_mismatch("status beat mismatch", want, got);
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_lines();
		test_random_lines();
		test_output_stall();
		test_sticky_fault();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_cnt == 0 && expected_status_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d beats missing", mismatch_cnt,
				expected_status_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
